// ===== sv/rpsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpsr_pkg
// Shared constants, types and GF(2^8) helpers for the P/Q syndrome engine.
// ----------------------------------------------------------------------------
package rpsr_pkg;

  localparam int unsigned MaxDrives = 64;
  localparam int unsigned IdxW      = $clog2(MaxDrives);
  localparam int unsigned CntW      = $clog2(MaxDrives + 3);
  localparam logic [CntW-1:0] PosMax = CntW'(MaxDrives + 2);

  // request codes
  localparam logic [2:0] ReqCompute = 3'd0;
  localparam logic [2:0] ReqRebP    = 3'd1;
  localparam logic [2:0] ReqRebQ    = 3'd2;
  localparam logic [2:0] ReqRebTwo  = 3'd3;
  localparam logic [2:0] ReqDetect  = 3'd4;

  // status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StCorrected = 2'd1;
  localparam logic [1:0] StUncorr    = 2'd2;
  localparam logic [1:0] StInvalid   = 2'd3;

  // config register indexes
  localparam logic CfgDriveCount = 1'b0;
  localparam logic CfgPolyLow    = 1'b1;

  // running stream state handed to the solver at the end of a stripe
  typedef struct packed {
    logic [7:0]      p_run;
    logic [7:0]      q_run;
    logic [7:0]      p_stored;
    logic [CntW-1:0] pos;
  } snap_t;

  function automatic logic [7:0] gf_x(input logic [7:0] a, input logic [7:0] poly);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if (a[7]) r = r ^ poly;
    return r;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] r;
    logic [7:0] t;
    r = '0;
    t = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ t;
      t = gf_x(t, poly);
    end
    return r;
  endfunction

endpackage

// ===== sv/rpsr_ram.sv =====
// ----------------------------------------------------------------------------
// rpsr_ram
// Stripe buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rpsr_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [rpsr_pkg::IdxW-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic [rpsr_pkg::IdxW-1:0] raddr_i,
  output logic [7:0]                rdata_o
);
  import rpsr_pkg::*;

  logic [7:0] mem_q [MaxDrives];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rpsr_solver.sv =====
// ----------------------------------------------------------------------------
// rpsr_solver
// End-of-stripe sequencer: reads the stripe buffer, walks powers of two,
// inverts by repeated squaring and builds the result transaction.
// ----------------------------------------------------------------------------
module rpsr_solver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic [2:0]                req_i,
  input  logic [rpsr_pkg::IdxW-1:0] f1_i,
  input  logic [rpsr_pkg::IdxW-1:0] f2_i,
  input  logic [7:0]                qb_i,
  input  rpsr_pkg::snap_t           snap_i,
  input  logic [rpsr_pkg::CntW-1:0] n_i,
  input  logic [7:0]                poly_i,
  output logic [rpsr_pkg::IdxW-1:0] rd_addr_o,
  input  logic [7:0]                rd_data_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [rpsr_pkg::IdxW-1:0] index_a_o,
  output logic [7:0]                value_a_o,
  output logic [rpsr_pkg::IdxW-1:0] index_b_o,
  output logic [7:0]                value_b_o,
  output logic [1:0]                status_o
);
  import rpsr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_RDA   = 12'b0000_0000_0010,
    S_RDB   = 12'b0000_0000_0100,
    S_RDC   = 12'b0000_0000_1000,
    S_POW   = 12'b0000_0001_0000,
    S_POSTP = 12'b0000_0010_0000,
    S_MULQ  = 12'b0000_0100_0000,
    S_INV0  = 12'b0000_1000_0000,
    S_INVL  = 12'b0001_0000_0000,
    S_INVD  = 12'b0010_0000_0000,
    S_RDS   = 12'b0100_0000_0000,
    S_RDT   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  logic [2:0]      req_q;
  logic [IdxW-1:0] f1_q, f2_q;
  logic [CntW-1:0] n_q, c_q, k_q;
  logic [7:0]      pd_q, qd_q, s1_q, s2_q, d1_q, d2_q, e_q, x_q;
  logic [7:0]      sq_q, inv_q, rr_q, y_q, op_q;
  logic            found_q, pass_q;
  logic [2:0]      icnt_q;

  logic [IdxW-1:0] idx_a_q, idx_b_q;
  logic [7:0]      val_a_q, val_b_q;
  logic [1:0]      st_q;

  logic            fin;
  logic [IdxW-1:0] fin_ia, fin_ib;
  logic [7:0]      fin_va, fin_vb;
  logic [1:0]      fin_st;

  logic [7:0]      pd0, qd0, qd_by_inv, y_by_inv;
  logic [CntW-1:0] n_last, corr_pos;
  logic [CntW-1:0] f1_w, f2_w, fi1_w, fi2_w;

  assign pd0       = snap_i.p_stored ^ snap_i.p_run;
  assign qd0       = qb_i ^ snap_i.q_run;
  assign qd_by_inv = gf_mul(qd_q, inv_q, poly_i);
  assign y_by_inv  = gf_mul(y_q, inv_q, poly_i);
  assign n_last    = n_q - CntW'(1);
  assign corr_pos  = n_last - k_q;
  assign f1_w      = CntW'(f1_q);
  assign f2_w      = CntW'(f2_q);
  assign fi1_w     = CntW'(f1_i);
  assign fi2_w     = CntW'(f2_i);

  always_comb begin
    state_d   = state_q;
    fin       = 1'b0;
    fin_ia    = '0;
    fin_ib    = '0;
    fin_va    = '0;
    fin_vb    = '0;
    fin_st    = StOk;
    rd_addr_o = f1_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          if (snap_i.pos != n_i + CntW'(1)) begin
            fin    = 1'b1;
            fin_st = StInvalid;
          end else begin
            unique case (req_i)
              ReqCompute: begin
                fin    = 1'b1;
                fin_va = snap_i.p_run;
                fin_vb = snap_i.q_run;
              end
              ReqRebP, ReqRebQ: begin
                if (fi1_w >= n_i) begin
                  fin    = 1'b1;
                  fin_st = StUncorr;
                end else begin
                  state_d = S_RDA;
                end
              end
              ReqRebTwo: begin
                if (f1_i >= f2_i) begin
                  fin    = 1'b1;
                  fin_st = StInvalid;
                end else if (fi2_w >= n_i) begin
                  fin    = 1'b1;
                  fin_st = StUncorr;
                end else begin
                  state_d = S_RDA;
                end
              end
              ReqDetect: begin
                if (pd0 == 8'd0 && qd0 == 8'd0) begin
                  fin = 1'b1;
                end else if (pd0 == 8'd0 || qd0 == 8'd0) begin
                  fin    = 1'b1;
                  fin_st = StUncorr;
                end else begin
                  state_d = S_INV0;
                end
              end
              default: begin
                fin    = 1'b1;
                fin_st = StInvalid;
              end
            endcase
          end
        end
      end
      S_RDA: begin
        rd_addr_o = f1_q;
        state_d   = S_RDB;
      end
      S_RDB: begin
        rd_addr_o = f2_q;
        state_d   = S_RDC;
      end
      S_RDC: begin
        if (req_q == ReqRebP) begin
          fin    = 1'b1;
          fin_ia = f1_q;
          fin_va = pd_q;
        end else begin
          state_d = S_POW;
        end
      end
      S_POW: begin
        if (c_q == n_last) state_d = S_POSTP;
      end
      S_POSTP: begin
        if (req_q == ReqDetect) begin
          if (found_q) begin
            state_d = S_RDS;
          end else begin
            fin    = 1'b1;
            fin_st = StUncorr;
          end
        end else begin
          state_d = S_MULQ;
        end
      end
      S_MULQ: begin
        if ((req_q == ReqRebQ && d1_q == 8'd0) ||
            (req_q == ReqRebTwo && (d2_q == 8'd0 || e_q == 8'd0))) begin
          fin    = 1'b1;
          fin_st = StUncorr;
        end else begin
          state_d = S_INV0;
        end
      end
      S_INV0: state_d = S_INVL;
      S_INVL: begin
        if (icnt_q == 3'd6) state_d = S_INVD;
      end
      S_INVD: begin
        if (req_q == ReqDetect) begin
          state_d = S_POW;
        end else if (req_q == ReqRebQ) begin
          fin    = 1'b1;
          fin_ia = f1_q;
          fin_va = qd_by_inv;
        end else if (!pass_q) begin
          state_d = S_INV0;
        end else begin
          fin    = 1'b1;
          fin_ia = f1_q;
          fin_va = y_by_inv;
          fin_ib = f2_q;
          fin_vb = pd_q ^ y_by_inv;
        end
      end
      S_RDS: begin
        rd_addr_o = corr_pos[IdxW-1:0];
        state_d   = S_RDT;
      end
      S_RDT: begin
        fin    = 1'b1;
        fin_ia = corr_pos[IdxW-1:0];
        fin_va = rd_data_i ^ pd_q;
        fin_st = StCorrected;
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      idx_a_q <= fin_ia;
      val_a_q <= fin_va;
      idx_b_q <= fin_ib;
      val_b_q <= fin_vb;
      st_q    <= fin_st;
    end
    unique case (state_q)
      S_IDLE: begin
        req_q  <= req_i;
        f1_q   <= f1_i;
        f2_q   <= f2_i;
        n_q    <= n_i;
        pd_q   <= pd0;
        qd_q   <= qd0;
        op_q   <= pd0;
        pass_q <= 1'b0;
      end
      S_RDB: begin
        s1_q <= rd_data_i;
        pd_q <= pd_q ^ rd_data_i;
      end
      S_RDC: begin
        s2_q <= rd_data_i;
        if (req_q == ReqRebTwo) pd_q <= pd_q ^ rd_data_i;
        x_q     <= 8'd1;
        c_q     <= '0;
        found_q <= 1'b0;
      end
      S_POW: begin
        if (c_q == n_last - f1_w) d1_q <= x_q;
        if (c_q == n_last - f2_w) d2_q <= x_q;
        if (c_q == f2_w - f1_w)   e_q  <= x_q ^ 8'd1;
        if (!found_q && x_q == rr_q) begin
          found_q <= 1'b1;
          k_q     <= c_q;
        end
        x_q <= gf_x(x_q, poly_i);
        c_q <= c_q + CntW'(1);
      end
      S_MULQ: begin
        qd_q <= qd_q ^ gf_mul(s1_q, d1_q, poly_i)
              ^ ((req_q == ReqRebTwo) ? gf_mul(s2_q, d2_q, poly_i) : 8'd0);
        op_q <= (req_q == ReqRebQ) ? d1_q : d2_q;
      end
      S_INV0: begin
        sq_q   <= gf_mul(op_q, op_q, poly_i);
        inv_q  <= 8'd1;
        icnt_q <= '0;
      end
      S_INVL: begin
        // inv collects a^2 * a^4 * ... * a^128 = a^254
        inv_q  <= gf_mul(inv_q, sq_q, poly_i);
        sq_q   <= gf_mul(sq_q, sq_q, poly_i);
        icnt_q <= icnt_q + 3'd1;
      end
      S_INVD: begin
        rr_q    <= qd_by_inv;
        x_q     <= 8'd1;
        c_q     <= '0;
        found_q <= 1'b0;
        y_q     <= qd_by_inv ^ pd_q;
        op_q    <= e_q;
        pass_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o    = (state_q != S_IDLE);
  assign done_o    = done_q;
  assign index_a_o = idx_a_q;
  assign value_a_o = val_a_q;
  assign index_b_o = idx_b_q;
  assign value_b_o = val_b_q;
  assign status_o  = st_q;

endmodule

// ===== sv/raid6_pq_syndrome_recovery_top.sv =====
// ----------------------------------------------------------------------------
// raid6_pq_syndrome_recovery_top
// RAID-6 P/Q syndrome engine over GF(2^8) with erasure rebuild and
// silent-corruption detection.
// ----------------------------------------------------------------------------
// Usage:
//  - A transaction is taken when start is high and busy is low. Each carries
//    one stripe byte: data drives 0..n-1, then P, then Q with is_last_i set.
//    The request fields are looked at only on the Q byte.
//  - Data, P and extra bytes do not start the solver; busy stays low.
//  - The Q byte starts the solver. Compute, wrong length, unknown request,
//    unordered pair, index out of range and detect with a clean or one-sided
//    difference finish at once: busy stays low and done_o is high in the
//    cycle after the Q byte. Other paths hold busy high while the solver
//    runs; done_o rises in the same cycle that busy drops. Rebuild from P
//    reads the buffer; rebuild from Q also walks powers of two (one step
//    per cycle over n drives) and inverts once, a double rebuild inverts
//    twice; both stop before inverting on a zero weight. A detect inverts,
//    walks and reads the corrected drive, or ends after the walk if none
//    matches. Each inverse: setup, 7 square-and-multiply steps, finish.
//  - The result shows for exactly one cycle with done_o high; the receiver
//    cannot stall it.
//  - Config (drive count, polynomial low byte) is written via cfg_we_i by
//    the user only while idle; the block does not check. Reset clears the
//    running syndromes, position and config (4 drives, 0x1D), not the buffer.
// ----------------------------------------------------------------------------
module raid6_pq_syndrome_recovery_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                req_type_i,
  input  logic [rpsr_pkg::IdxW-1:0] failed_first_i,
  input  logic [rpsr_pkg::IdxW-1:0] failed_second_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      is_last_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [7:0]                cfg_data_i,
  output logic                      done_o,
  output logic [rpsr_pkg::IdxW-1:0] index_a_o,
  output logic [7:0]                value_a_o,
  output logic [rpsr_pkg::IdxW-1:0] index_b_o,
  output logic [7:0]                value_b_o,
  output logic [1:0]                status_o
);
  import rpsr_pkg::*;

  logic [6:0]      drive_count_q;
  logic [7:0]      poly_q;
  logic [7:0]      p_run_q, q_run_q, p_stored_q;
  logic [CntW-1:0] pos_q;

  logic            accept, last_acc, data_acc, mem_we;
  logic [CntW-1:0] n_drv;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]      rd_data;
  snap_t           snap;

  assign accept   = start && !busy;
  assign last_acc = accept && is_last_i;
  assign data_acc = accept && !is_last_i;
  assign mem_we   = data_acc && (pos_q < n_drv);

  // clamp the drive count to 2..MaxDrives
  always_comb begin
    if (drive_count_q < 7'd2) n_drv = CntW'(2);
    else if (CntW'(drive_count_q) > CntW'(MaxDrives)) n_drv = CntW'(MaxDrives);
    else n_drv = CntW'(drive_count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_count_q <= 7'd4;
      poly_q        <= 8'h1D;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDriveCount: drive_count_q <= cfg_data_i[6:0];
        CfgPolyLow:    poly_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // running syndromes: P is plain XOR, Q is Horner with generator 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_run_q    <= '0;
      q_run_q    <= '0;
      p_stored_q <= '0;
      pos_q      <= '0;
    end else if (last_acc) begin
      p_run_q    <= '0;
      q_run_q    <= '0;
      p_stored_q <= '0;
      pos_q      <= '0;
    end else if (data_acc) begin
      if (pos_q < n_drv) begin
        p_run_q <= p_run_q ^ data_byte_i;
        q_run_q <= gf_x(q_run_q, poly_q) ^ data_byte_i;
      end else if (pos_q == n_drv) begin
        p_stored_q <= data_byte_i;
      end
      if (pos_q < PosMax) pos_q <= pos_q + CntW'(1);
    end
  end

  assign snap.p_run    = p_run_q;
  assign snap.q_run    = q_run_q;
  assign snap.p_stored = p_stored_q;
  assign snap.pos      = pos_q;

  rpsr_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q[IdxW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  rpsr_solver u_solver (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (last_acc),
    .req_i     (req_type_i),
    .f1_i      (failed_first_i),
    .f2_i      (failed_second_i),
    .qb_i      (data_byte_i),
    .snap_i    (snap),
    .n_i       (n_drv),
    .poly_i    (poly_q),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .busy_o    (busy),
    .done_o    (done_o),
    .index_a_o (index_a_o),
    .value_a_o (value_a_o),
    .index_b_o (index_b_o),
    .value_b_o (value_b_o),
    .status_o  (status_o)
  );

endmodule

// ===== bench/raid6_pq_syndrome_recovery_top_test.sv =====
// ----------------------------------------------------------------------------
// raid6_pq_syndrome_recovery_top_test
// Self-checking bench for the RAID-6 P/Q engine: streams stripes through the
// command port, mirrors the syndrome math in a local model and compares every
// result strobe against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module raid6_pq_syndrome_recovery_top_test;
  import rpsr_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0] idx_a;
    logic [7:0]      val_a;
    logic [IdxW-1:0] idx_b;
    logic [7:0]      val_b;
    logic [1:0]      st;
  } recovery_t;

  // directed row: typed rows carry a hand-written status, all else zero
  typedef struct packed {
    logic [2:0]      req;
    logic [IdxW-1:0] f1;
    logic [IdxW-1:0] f2;
    logic [7:0]      dbyte;
    logic            last;
    logic            typed;
    logic [1:0]      st;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [2:0]      req_type_i = '0;
  logic [IdxW-1:0] failed_first_i = '0;
  logic [IdxW-1:0] failed_second_i = '0;
  logic [7:0]      data_byte_i = '0;
  logic            is_last_i = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_idx_i = 1'b0;
  logic [7:0]      cfg_data_i = '0;
  logic            done_o;
  logic [IdxW-1:0] index_a_o;
  logic [7:0]      value_a_o;
  logic [IdxW-1:0] index_b_o;
  logic [7:0]      value_b_o;
  logic [1:0]      status_o;

  raid6_pq_syndrome_recovery_top u_top (.*);

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Local model state: running syndromes, position, stored P, stripe buffer
  // and the two config registers as last written.
  // --------------------------------------------------------------------------
  logic [6:0]      drv_cnt = 7'd4;
  logic [7:0]      poly_lo = 8'd29;
  logic [7:0]      p_acc = '0;
  logic [7:0]      q_acc = '0;
  logic [7:0]      p_held = '0;
  int unsigned     stripe_pos = 0;
  logic [7:0]      stripe_buf [MaxDrives];

  recovery_t       pending_q [$];
  int unsigned     err_cnt = 0;
  int unsigned     items_done = 0;
  int unsigned     idle_pct = 0;

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? poly_lo : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] a);
    logic [7:0] r;
    r = 8'd1;
    for (int i = 0; i < 254; i++) r = gf_prod(r, a);
    return r;
  endfunction

  function automatic logic [7:0] gf_two_pow(input int unsigned e);
    logic [7:0] r;
    r = 8'd1;
    for (int unsigned i = 0; i < e; i++) r = gf_dbl(r);
    return r;
  endfunction

  function automatic int unsigned active_drives();
    if (drv_cnt < 2) return 2;
    if (drv_cnt > MaxDrives) return MaxDrives;
    return int'(drv_cnt);
  endfunction

  // Solver for the Q byte; n is the clamped drive count.
  function automatic recovery_t solve_stripe(input logic [2:0] req, input int unsigned f1,
                                             input int unsigned f2, input logic [7:0] qb,
                                             input int unsigned n);
    recovery_t  r;
    logic [7:0] pd, qd, den, e, a;
    int         lg;
    r = '0;
    case (req)
      ReqCompute: begin
        r.val_a = p_acc;
        r.val_b = q_acc;
      end
      ReqRebP, ReqRebQ: begin
        if (f1 >= n) begin
          r.st = StUncorr;
        end else begin
          pd = p_held ^ p_acc ^ stripe_buf[f1];
          qd = qb ^ q_acc ^ gf_prod(stripe_buf[f1], gf_two_pow(n - 1 - f1));
          r.idx_a = IdxW'(f1);
          if (req == ReqRebP) begin
            r.val_a = pd;
          end else begin
            den = gf_two_pow(n - 1 - f1);
            if (den == 0) begin
              r.idx_a = '0;
              r.st    = StUncorr;
            end else begin
              r.val_a = gf_prod(qd, gf_recip(den));
            end
          end
        end
      end
      ReqRebTwo: begin
        if (f1 >= f2) begin
          r.st = StInvalid;
        end else if (f2 >= n) begin
          r.st = StUncorr;
        end else begin
          pd  = p_held ^ p_acc ^ stripe_buf[f1] ^ stripe_buf[f2];
          qd  = qb ^ q_acc ^ gf_prod(stripe_buf[f1], gf_two_pow(n - 1 - f1))
                ^ gf_prod(stripe_buf[f2], gf_two_pow(n - 1 - f2));
          den = gf_two_pow(n - 1 - f2);
          e   = gf_two_pow(f2 - f1) ^ 8'd1;
          if (den == 0 || e == 0) begin
            r.st = StUncorr;
          end else begin
            a       = gf_prod(gf_prod(qd, gf_recip(den)) ^ pd, gf_recip(e));
            r.idx_a = IdxW'(f1);
            r.val_a = a;
            r.idx_b = IdxW'(f2);
            r.val_b = pd ^ a;
          end
        end
      end
      ReqDetect: begin
        pd = p_held ^ p_acc;
        qd = qb ^ q_acc;
        if (pd == 0 && qd == 0) begin
          r.st = StOk;
        end else if (pd == 0 || qd == 0) begin
          r.st = StUncorr;
        end else begin
          // locate the drive whose weight equals Q diff / P diff
          a  = gf_prod(qd, gf_recip(pd));
          lg = -1;
          e  = 8'd1;
          for (int k = 0; k < 255; k++) begin
            if (lg < 0 && e == a) lg = k;
            e = gf_dbl(e);
          end
          if (lg < 0 || lg > int'(n) - 1) begin
            r.st = StUncorr;
          end else begin
            r.idx_a = IdxW'(int'(n) - 1 - lg);
            r.val_a = stripe_buf[int'(n) - 1 - lg] ^ pd;
            r.st    = StCorrected;
          end
        end
      end
      default: r.st = StInvalid;
    endcase
    return r;
  endfunction

  // Advance the model by one accepted transaction; returns 1 when a result
  // is due, with the expectation in res.
  function automatic bit track_item(input logic [2:0] req, input logic [IdxW-1:0] f1,
                                    input logic [IdxW-1:0] f2, input logic [7:0] b,
                                    input logic last, output recovery_t res);
    int unsigned n;
    n   = active_drives();
    res = '0;
    if (!last) begin
      if (stripe_pos < n) begin
        stripe_buf[stripe_pos] = b;
        p_acc ^= b;
        q_acc = gf_dbl(q_acc) ^ b;
      end else if (stripe_pos == n) begin
        p_held = b;
      end
      if (stripe_pos < MaxDrives + 2) stripe_pos++;
      return 1'b0;
    end
    if (stripe_pos != n + 1) res.st = StInvalid;
    else res = solve_stripe(req, f1, f2, b, n);
    p_acc = '0;
    q_acc = '0;
    p_held = '0;
    stripe_pos = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Result checker: done_o is a one-cycle strobe, sampled at the closing edge.
  always @(posedge clk_i) begin
    recovery_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", status_o, -1);
      end else begin
        want = pending_q.pop_front();
        if (index_a_o !== want.idx_a) report_mismatch("index_a", index_a_o, want.idx_a);
        if (value_a_o !== want.val_a) report_mismatch("value_a", value_a_o, want.val_a);
        if (index_b_o !== want.idx_b) report_mismatch("index_b", index_b_o, want.idx_b);
        if (value_b_o !== want.val_b) report_mismatch("value_b", value_b_o, want.val_b);
        if (status_o !== want.st) report_mismatch("status", status_o, want.st);
      end
    end
  end

  // Present one transaction and hold it until the engine takes it. The
  // optional idle gap in front holds start low between items.
  task automatic send_item(input logic [2:0] req, input logic [IdxW-1:0] f1,
                           input logic [IdxW-1:0] f2, input logic [7:0] b,
                           input logic last, input bit typed, input logic [1:0] st);
    recovery_t res;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    start           <= 1'b1;
    req_type_i      <= req;
    failed_first_i  <= f1;
    failed_second_i <= f2;
    data_byte_i     <= b;
    is_last_i       <= last;
    do @(posedge clk_i); while (busy);
    items_done++;
    if (track_item(req, f1, f2, b, last, res)) begin
      if (typed) begin
        res    = '0;
        res.st = st;
      end
      pending_q.push_back(res);
    end
  endtask

  // Filler item: random request fields, never the Q marker.
  task automatic send_byte(input logic [7:0] b);
    send_item(3'($urandom_range(7)), IdxW'($urandom_range(63)), IdxW'($urandom_range(63)),
              b, 1'b0, 1'b0, StOk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // the last item may have been a plain byte still in flight
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDriveCount) drv_cnt = val[6:0];
    else poly_lo = val;
  endtask

  // One random stripe: mostly well formed, with corruption, bad lengths,
  // odd requests and stray items mixed in.
  task automatic send_stripe();
    int unsigned n, f1, f2, len, k;
    logic [2:0]  req;
    logic [7:0]  dat [MaxDrives];
    logic [7:0]  p, q;
    n = active_drives();
    if ($urandom_range(9) == 0) begin
      send_item(3'($urandom_range(7)), IdxW'($urandom_range(63)), IdxW'($urandom_range(63)),
                8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, StOk);
      return;
    end
    req = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    if ($urandom_range(9) == 0) begin
      f1 = $urandom_range(63);
      f2 = $urandom_range(63);
    end else begin
      f1 = $urandom_range(n - 2);
      f2 = $urandom_range(n - 1, f1 + 1);
    end
    p = '0;
    q = '0;
    for (int i = 0; i < n; i++) begin
      dat[i] = 8'($urandom_range(255));
      p ^= dat[i];
      q = gf_dbl(q) ^ dat[i];
    end
    case ($urandom_range(3))
      1: dat[$urandom_range(n - 1)] ^= 8'($urandom_range(255, 1));
      2: p ^= 8'($urandom_range(255, 1));
      3: q ^= 8'($urandom_range(255, 1));
      default: ;
    endcase
    k   = $urandom_range(19);
    len = (k == 0) ? n - 1 : n;
    for (int i = 0; i < len; i++) send_byte(dat[i]);
    send_byte(p);
    if (k == 1) repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    send_item(req, IdxW'(f1), IdxW'(f2), q, 1'b1, 1'b0, StOk);
  endtask

  // Directed rows at reset config (4 drives). Typed rows are error cases.
  dir_row_t dir_rows [25] = '{
    // Q marker with no stripe: wrong length
    '{ReqCompute, 6'd0, 6'd0, 8'h00, 1'b1, 1'b1, StInvalid},
    // compute on extreme data, extreme request fields
    '{ReqDetect,  6'd63, 6'd63, 8'h00, 1'b0, 1'b0, StOk},
    '{ReqRebTwo,  6'd63, 6'd0,  8'hFF, 1'b0, 1'b0, StOk},
    '{ReqRebQ,    6'd0,  6'd63, 8'h80, 1'b0, 1'b0, StOk},
    '{3'd7,       6'd42, 6'd21, 8'h01, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd21, 6'd42, 8'hFF, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd63, 6'd63, 8'h00, 1'b1, 1'b0, StOk},
    // unknown request code
    '{ReqCompute, 6'd0, 6'd0, 8'h11, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h22, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h33, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h44, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h44, 1'b0, 1'b0, StOk},
    '{3'd5,       6'd0, 6'd0, 8'h7E, 1'b1, 1'b1, StInvalid},
    // unordered failed pair
    '{ReqCompute, 6'd0, 6'd0, 8'hA5, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h5A, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'hC3, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h3C, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0, StOk},
    '{ReqRebTwo,  6'd3, 6'd3, 8'h9D, 1'b1, 1'b1, StInvalid},
    // failed index beyond drive count
    '{ReqCompute, 6'd0, 6'd0, 8'h10, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h20, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h30, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h40, 1'b0, 1'b0, StOk},
    '{ReqCompute, 6'd0, 6'd0, 8'h40, 1'b0, 1'b0, StOk},
    '{ReqRebP,    6'd63, 6'd0, 8'h55, 1'b1, 1'b1, StUncorr}
  };

  // phase settings: drive count, polynomial low byte, sender idle percent
  int unsigned ph_drv  [6] = '{7, 2,  127, 0,  64, 16};
  int unsigned ph_poly [6] = '{29, 29, 29, 0, 255, 8'h4D};
  int unsigned ph_idle [6] = '{0, 86, 0,  23, 0,  86};

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_item(dir_rows[i].req, dir_rows[i].f1, dir_rows[i].f2, dir_rows[i].dbyte,
                dir_rows[i].last, dir_rows[i].typed, dir_rows[i].st);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(CfgDriveCount, 8'(ph_drv[ph]));
      write_reg(CfgPolyLow, 8'(ph_poly[ph]));
      idle_pct = ph_idle[ph];
      while (items_done < 25 + (ph + 1) * 330) send_stripe();
    end

    drain();
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== raid6_pq_syndrome_recovery_top.f =====
sv/rpsr_pkg.sv
sv/rpsr_ram.sv
sv/rpsr_solver.sv
sv/raid6_pq_syndrome_recovery_top.sv
bench/raid6_pq_syndrome_recovery_top_test.sv
